// ----- rtl/core/bmrs_pkg.sv -----
// shared types and constants for the bunch mean, rms and survival statistics block
package bmrs_pkg;

   localparam int MEAN_OUT_W  = 24;
   localparam int RMS_OUT_W   = 24;
   localparam int FRAC_OUT_W  = 17;
   localparam int COUNT_OUT_W = 17;
   localparam int FRAC_SHIFT  = 16;
   localparam logic [FRAC_OUT_W-1:0] FRAC_ONE = 17'h10000;

   typedef struct packed {
      logic accept;
      logic ld_mean;
      logic ld_sq;
      logic ld_frac;
      logic div_step;
      logic cap_mean;
      logic cap_var;
      logic cap_frac;
      logic ld_root;
      logic root_step;
      logic capture;
   } cmd_type;

   typedef struct packed {
      logic last_acc;
   } status_type;

endpackage

// ----- rtl/core/bmrs_div.sv -----
// restoring divider, one quotient bit per cycle while step is high
module bmrs_div #(
   parameter int DVD_W = 63,
   parameter int DVS_W = 17
) (
   input  logic             clock,
   input  logic             load,
   input  logic             step,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient
);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             ge;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (load) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (step) begin
         rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;

endmodule

// ----- rtl/core/bmrs_isqrt.sv -----
// integer square root, two value bits and one root bit per cycle while step is high
module bmrs_isqrt #(
   parameter int VAL_W = 64
) (
   input  logic               clock,
   input  logic               load,
   input  logic               step,
   input  logic [VAL_W-1:0]   value,
   output logic [VAL_W/2-1:0] root
);

   localparam int RW = VAL_W / 2;

   logic [VAL_W-1:0] val_ff, val_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [RW-1:0]    root_ff, root_in;
   logic [RW+1:0]    remx;
   logic [RW+1:0]    trial;
   logic [RW+1:0]    diff;
   logic             ge;

   assign remx  = {rem_ff, val_ff[VAL_W-1 -: 2]};
   assign trial = {root_ff, 2'b01};
   assign ge    = remx >= trial;
   assign diff  = remx - trial;

   // remainder stays below 2^RW until the final step, whose remainder is dropped
   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (load) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
      end else if (step) begin
         val_in  = {val_ff[VAL_W-3:0], 2'b00};
         rem_in  = ge ? diff[RW-1:0] : remx[RW-1:0];
         root_in = {root_ff[RW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule

// ----- rtl/core/bmrs_dpath.sv -----
// datapath: square stage, accumulators, divider, square root and result register
module bmrs_dpath #(
   parameter int POSITION_BITS = 24,
   parameter int MAX_PARTICLES = 65536
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  bmrs_pkg::cmd_type                          cmd,
   output bmrs_pkg::status_type                       status,
   input  logic signed [POSITION_BITS-1:0]            req_x_position,
   input  logic                                       req_alive,
   input  logic                                       req_last_particle,
   output logic signed [bmrs_pkg::MEAN_OUT_W-1:0]     rsp_x_mean,
   output logic        [bmrs_pkg::RMS_OUT_W-1:0]      rsp_x_rms,
   output logic        [bmrs_pkg::FRAC_OUT_W-1:0]     rsp_surv_frac,
   output logic        [bmrs_pkg::COUNT_OUT_W-1:0]    rsp_alive_total
);

   localparam int PB      = POSITION_BITS;
   localparam int CNT_W   = $clog2(MAX_PARTICLES + 1);
   localparam int SX_W    = PB + CNT_W;
   localparam int SQ_W    = 2 * PB - 2 + CNT_W;
   localparam int FN_W    = CNT_W + bmrs_pkg::FRAC_SHIFT;
   localparam int DIV_W   = (SQ_W > FN_W) ? SQ_W : FN_W;
   localparam int ROOT_VW = SQ_W + (SQ_W % 2);
   localparam int ROOT_W  = ROOT_VW / 2;
   localparam int MW      = bmrs_pkg::MEAN_OUT_W;
   localparam int RMW     = bmrs_pkg::RMS_OUT_W;
   localparam int FW      = bmrs_pkg::FRAC_OUT_W;
   localparam int AW      = bmrs_pkg::COUNT_OUT_W;

   // square stage
   logic                 st_valid_ff;
   logic                 st_alive_ff;
   logic                 st_last_ff;
   logic signed [PB-1:0] st_x_ff;
   logic [2*PB-1:0]      st_sq_ff;
   logic signed [2*PB-1:0] x_ext;
   logic signed [2*PB-1:0] sq_full;

   // accumulators
   logic [SX_W-1:0]  sum_x_ff, sum_x_in;
   logic [SQ_W-1:0]  sum_sq_ff, sum_sq_in;
   logic [CNT_W-1:0] acnt_ff, acnt_in;
   logic [CNT_W-1:0] pcnt_ff, pcnt_in;
   logic             count_ok;

   // finishing
   logic [DIV_W-1:0]  div_dvd;
   logic [CNT_W-1:0]  div_dvs;
   logic [DIV_W-1:0]  div_quo;
   logic              div_load;
   logic              sneg;
   logic [SX_W-1:0]   smag;
   logic [PB-1:0]     mmag_ff;
   logic [2*PB-1:0]   msq_ff;
   logic [SQ_W-1:0]   q_val;
   logic [SQ_W-1:0]   msq_c;
   logic [SQ_W-1:0]   var_ff;
   logic [FW-1:0]     frac_ff;
   logic [ROOT_W-1:0] root;
   logic              n_zero;
   logic [PB+MW-1:0]  mean_ext;
   logic [PB+MW-1:0]  mean_sgn;
   logic [ROOT_W+RMW-1:0] rms_ext;
   logic [CNT_W+AW-1:0]   alive_ext;

   assign x_ext   = {{PB{req_x_position[PB-1]}}, req_x_position};
   assign sq_full = x_ext * x_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= cmd.accept;
      end
      if (cmd.accept) begin
         st_x_ff     <= req_x_position;
         st_alive_ff <= req_alive;
         st_last_ff  <= req_last_particle;
         st_sq_ff    <= sq_full;
      end
   end

   assign status.last_acc = st_valid_ff & st_last_ff;

   // particles past the limit are dropped from sums and counts
   assign count_ok = pcnt_ff < CNT_W'(MAX_PARTICLES);

   always_comb begin
      sum_x_in  = sum_x_ff;
      sum_sq_in = sum_sq_ff;
      acnt_in   = acnt_ff;
      pcnt_in   = pcnt_ff;
      if (cmd.capture) begin
         sum_x_in  = '0;
         sum_sq_in = '0;
         acnt_in   = '0;
         pcnt_in   = '0;
      end else if (st_valid_ff && count_ok) begin
         pcnt_in = pcnt_ff + 1'b1;
         if (st_alive_ff) begin
            sum_x_in  = sum_x_ff + {{CNT_W{st_x_ff[PB-1]}}, st_x_ff};
            sum_sq_in = sum_sq_ff + SQ_W'(st_sq_ff);
            acnt_in   = acnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff  <= '0;
         sum_sq_ff <= '0;
         acnt_ff   <= '0;
         pcnt_ff   <= '0;
      end else begin
         sum_x_ff  <= sum_x_in;
         sum_sq_ff <= sum_sq_in;
         acnt_ff   <= acnt_in;
         pcnt_ff   <= pcnt_in;
      end
   end

   // divider operand select: mean, mean square, survival fraction
   assign sneg = sum_x_ff[SX_W-1];
   assign smag = sneg ? (~sum_x_ff + 1'b1) : sum_x_ff;

   always_comb begin
      if (cmd.ld_mean) begin
         div_dvd = DIV_W'(smag);
      end else if (cmd.ld_sq) begin
         div_dvd = DIV_W'(sum_sq_ff);
      end else begin
         div_dvd = DIV_W'({acnt_ff, {bmrs_pkg::FRAC_SHIFT{1'b0}}});
      end
   end

   assign div_dvs  = cmd.ld_frac ? pcnt_ff : acnt_ff;
   assign div_load = cmd.ld_mean | cmd.ld_sq | cmd.ld_frac;

   bmrs_div #(
      .DVD_W (DIV_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .load     (div_load),
      .step     (cmd.div_step),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (div_quo)
   );

   assign q_val = div_quo[SQ_W-1:0];
   assign msq_c = SQ_W'(msq_ff);

   always_ff @(posedge clock) begin
      msq_ff <= mmag_ff * mmag_ff;
      if (cmd.cap_mean) begin
         mmag_ff <= div_quo[PB-1:0];
      end
      if (cmd.cap_var) begin
         var_ff <= (q_val > msq_c) ? (q_val - msq_c) : '0;
      end
      if (cmd.cap_frac) begin
         frac_ff <= div_quo[FW-1:0];
      end
   end

   bmrs_isqrt #(
      .VAL_W (ROOT_VW)
   ) u_isqrt (
      .clock (clock),
      .load  (cmd.ld_root),
      .step  (cmd.root_step),
      .value (ROOT_VW'(var_ff)),
      .root  (root)
   );

   assign n_zero    = acnt_ff == '0;
   assign mean_ext  = {{MW{1'b0}}, mmag_ff};
   assign mean_sgn  = sneg ? (~mean_ext + 1'b1) : mean_ext;
   assign rms_ext   = {{RMW{1'b0}}, root};
   assign alive_ext = {{AW{1'b0}}, acnt_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rsp_x_mean      <= n_zero ? '0 : mean_sgn[MW-1:0];
         rsp_x_rms       <= n_zero ? '0 : rms_ext[RMW-1:0];
         rsp_surv_frac   <= frac_ff;
         rsp_alive_total <= alive_ext[AW-1:0];
      end
   end

endmodule

// ----- rtl/core/bmrs_ctrl.sv -----
// controller: accepts particles, then sequences the divide and root passes per bunch
module bmrs_ctrl #(
   parameter int DIV_STEPS  = 63,
   parameter int ROOT_STEPS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_particle,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   input  bmrs_pkg::status_type status,
   output bmrs_pkg::cmd_type    cmd
);

   localparam int STEP_W = $clog2(DIV_STEPS + 1);

   typedef enum logic [3:0] {
      ST_ACCUM,
      ST_DRAIN,
      ST_MEAN_LD,
      ST_MEAN_RUN,
      ST_SQ_LD,
      ST_SQ_RUN,
      ST_FRAC_LD,
      ST_FRAC_RUN,
      ST_ROOT_LD,
      ST_ROOT_RUN,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              step_done;
   logic              out_free;

   assign step_done = step_ff == '0;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_ACCUM: begin
            cmd.accept = req_valid;
            if (req_valid && req_last_particle) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last word leaves the square stage this cycle
            if (status.last_acc) begin
               state_in = ST_MEAN_LD;
            end
         end
         ST_MEAN_LD: begin
            cmd.ld_mean = 1'b1;
            step_in     = STEP_W'(DIV_STEPS - 1);
            state_in    = ST_MEAN_RUN;
         end
         ST_MEAN_RUN: begin
            cmd.div_step = 1'b1;
            if (step_done) begin
               state_in = ST_SQ_LD;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_SQ_LD: begin
            cmd.cap_mean = 1'b1;
            cmd.ld_sq    = 1'b1;
            step_in      = STEP_W'(DIV_STEPS - 1);
            state_in     = ST_SQ_RUN;
         end
         ST_SQ_RUN: begin
            cmd.div_step = 1'b1;
            if (step_done) begin
               state_in = ST_FRAC_LD;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_FRAC_LD: begin
            cmd.cap_var = 1'b1;
            cmd.ld_frac = 1'b1;
            step_in     = STEP_W'(DIV_STEPS - 1);
            state_in    = ST_FRAC_RUN;
         end
         ST_FRAC_RUN: begin
            cmd.div_step = 1'b1;
            if (step_done) begin
               state_in = ST_ROOT_LD;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_ROOT_LD: begin
            cmd.cap_frac = 1'b1;
            cmd.ld_root  = 1'b1;
            step_in      = STEP_W'(ROOT_STEPS - 1);
            state_in     = ST_ROOT_RUN;
         end
         ST_ROOT_RUN: begin
            cmd.root_step = 1'b1;
            if (step_done) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.capture  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_ACCUM;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/beam_mean_rms_survival_stats.sv -----
// Bunch statistics. Particles stream in one word per cycle while req_ready is
// high; alive particles are summed (x and x squared) through a one-stage
// squaring pipeline. A word with last_particle set closes the bunch: req_ready
// drops, and the result is computed by one shared bit-serial divider run three
// times (mean, mean of squares, survival fraction) and a bit-serial square
// root. The next bunch is accepted as soon as the result is in the output
// register, even while that result waits for rsp_ready. Particles beyond
// MAX_PARTICLES in one bunch are ignored except for their last marker. With no
// alive particles the mean and rms read zero.
module beam_mean_rms_survival_stats #(
   parameter int POSITION_BITS = 24,
   parameter int MAX_PARTICLES = 65536
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [POSITION_BITS-1:0]         req_x_position,
   input  logic                                    req_alive,
   input  logic                                    req_last_particle,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [bmrs_pkg::MEAN_OUT_W-1:0]  rsp_x_mean,
   output logic        [bmrs_pkg::RMS_OUT_W-1:0]   rsp_x_rms,
   output logic        [bmrs_pkg::FRAC_OUT_W-1:0]  rsp_surv_frac,
   output logic        [bmrs_pkg::COUNT_OUT_W-1:0] rsp_alive_total
);

   localparam int CNT_W      = $clog2(MAX_PARTICLES + 1);
   localparam int SQ_W       = 2 * POSITION_BITS - 2 + CNT_W;
   localparam int FN_W       = CNT_W + bmrs_pkg::FRAC_SHIFT;
   localparam int DIV_W      = (SQ_W > FN_W) ? SQ_W : FN_W;
   localparam int ROOT_STEPS = (SQ_W + (SQ_W % 2)) / 2;

   bmrs_pkg::cmd_type    cmd;
   bmrs_pkg::status_type status;

   bmrs_ctrl #(
      .DIV_STEPS  (DIV_W),
      .ROOT_STEPS (ROOT_STEPS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_last_particle (req_last_particle),
      .req_ready         (req_ready),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .status            (status),
      .cmd               (cmd)
   );

   bmrs_dpath #(
      .POSITION_BITS (POSITION_BITS),
      .MAX_PARTICLES (MAX_PARTICLES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_x_position    (req_x_position),
      .req_alive         (req_alive),
      .req_last_particle (req_last_particle),
      .rsp_x_mean        (rsp_x_mean),
      .rsp_x_rms         (rsp_x_rms),
      .rsp_surv_frac     (rsp_surv_frac),
      .rsp_alive_total   (rsp_alive_total)
   );

endmodule

// ----- rtl/core/bmrs_chk.sv -----
// port-level checks for the bunch statistics block, bound to the top level
module bmrs_chk (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    req_last_particle,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [bmrs_pkg::MEAN_OUT_W-1:0]  rsp_x_mean,
   input logic        [bmrs_pkg::RMS_OUT_W-1:0]   rsp_x_rms,
   input logic        [bmrs_pkg::FRAC_OUT_W-1:0]  rsp_surv_frac,
   input logic        [bmrs_pkg::COUNT_OUT_W-1:0] rsp_alive_total
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x_mean) && $stable(rsp_x_rms)
         && $stable(rsp_surv_frac) && $stable(rsp_alive_total))
      else $error("result word changed while stalled");

   // closing a bunch stops intake until its result is built
   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_particle |=> !req_ready)
      else $error("input still ready right after the last particle");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_surv_frac <= bmrs_pkg::FRAC_ONE)
      else $error("survival fraction above one");

   // a bunch with no alive particles reports all zero statistics
   a_empty_bunch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alive_total == '0 |->
         rsp_x_mean == '0 && rsp_x_rms == '0 && rsp_surv_frac == '0)
      else $error("nonzero statistics with no alive particles");

endmodule

bind beam_mean_rms_survival_stats bmrs_chk u_bmrs_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_last_particle (req_last_particle),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_x_mean        (rsp_x_mean),
   .rsp_x_rms         (rsp_x_rms),
   .rsp_surv_frac     (rsp_surv_frac),
   .rsp_alive_total   (rsp_alive_total)
);
